// ===== rtl/core/ohfe_pkg.sv =====
// Shared types and constants for the OSPF Hello field extractor.
// Used by the output channel interface, the parser, the result queue and the top level.

package ohfe_pkg;

	localparam int MAX_NBRS = 32;
	localparam int NBR_W = 6;
	localparam int POS_W = 16;

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [POS_W-1:0] ETHERTYPE_LO_POS = 16'd13;
	localparam logic [POS_W-1:0] ETH_LEN = 16'd14;
	localparam logic [POS_W-1:0] IP_PROTO_POS = 16'd23;
	localparam logic [POS_W-1:0] OSPF_LEN = 16'd24;
	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [3:0] IP_VERSION = 4'd4;
	localparam logic [5:0] IP_MIN = 6'd20;
	localparam logic [7:0] PROTO_OSPF = 8'd89;
	localparam logic [7:0] TYPE_HELLO = 8'd1;

	localparam logic [POS_W-1:0] OFS_TYPE = 16'd1;
	localparam logic [POS_W-1:0] OFS_ROUTER = 16'd7;
	localparam logic [POS_W-1:0] OFS_AREA = 16'd11;
	localparam logic [POS_W-1:0] OFS_MASK = 16'd3;
	localparam logic [POS_W-1:0] OFS_INTERVAL = 16'd5;
	localparam logic [POS_W-1:0] OFS_DEAD = 16'd11;
	localparam logic [POS_W-1:0] OFS_DR = 16'd15;
	localparam logic [POS_W-1:0] OFS_BDR = 16'd19;
	localparam logic [POS_W-1:0] HELLO_FIXED = 16'd20;

	typedef enum logic [1:0] {
		KIND_SUMMARY = 2'd0,
		KIND_NEIGHBOR = 2'd1,
		KIND_END = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic [31:0] rtr_id;
		logic [31:0] area_id;
		logic [31:0] net_mask;
		logic [15:0] hello_period;
		logic [31:0] dead_period;
		logic [31:0] designated_router;
		logic [31:0] backup_router;
		logic [31:0] neighbor_addr;
		logic [NBR_W-1:0] neighbor_total;
		logic last;
	} result_t;

	typedef struct packed {
		logic [1:0] n;
		result_t slot0;
		result_t slot1;
	} push_t;

endpackage

// ===== rtl/core/ohfe_in_if.sv =====
// Byte channel into the extractor: one frame byte and its end-of-frame flag.
// Depends on nothing else.

interface ohfe_in_if;
	logic valid;
	logic ready;
	logic [7:0] data_byte;
	logic frame_end;

	modport source (output valid, output data_byte, output frame_end, input ready);
	modport sink (input valid, input data_byte, input frame_end, output ready);
endinterface

// ===== rtl/core/ohfe_out_if.sv =====
// Result channel out of the extractor: summary, neighbor and end words.
// Depends on ohfe_pkg for the word kind type.

interface ohfe_out_if;
	logic valid;
	logic ready;
	ohfe_pkg::kind_t kind;
	logic [31:0] rtr_id;
	logic [31:0] area_id;
	logic [31:0] net_mask;
	logic [15:0] hello_period;
	logic [31:0] dead_period;
	logic [31:0] designated_router;
	logic [31:0] backup_router;
	logic [31:0] neighbor_addr;
	logic [ohfe_pkg::NBR_W-1:0] neighbor_total;
	logic last;

	modport source (output valid, output kind, output rtr_id, output area_id,
		output net_mask, output hello_period, output dead_period,
		output designated_router, output backup_router, output neighbor_addr,
		output neighbor_total, output last, input ready);
	modport sink (input valid, input kind, input rtr_id, input area_id,
		input net_mask, input hello_period, input dead_period,
		input designated_router, input backup_router, input neighbor_addr,
		input neighbor_total, input last, output ready);
endinterface

// ===== rtl/core/ohfe_parser.sv =====
// Input register, per-frame parse state and the byte decision logic.
// Depends on ohfe_pkg and ohfe_in_if; pushes up to two result words per byte.

module ohfe_parser (
	input logic clk,
	input logic arst_n,
	ohfe_in_if.sink frame,
	input logic room,
	output ohfe_pkg::push_t push
);

	logic vld_s1;
	logic [7:0] byte_s1;
	logic fin_s1;

	logic [ohfe_pkg::POS_W-1:0] pos_q, pos_d;
	logic [5:0] ihl_q, ihl_d;
	logic rej_q, rej_d;
	logic hello_q, hello_d;
	logic [31:0] shift_q, shift_d;
	logic [31:0] router_q, router_d;
	logic [31:0] area_q, area_d;
	logic [31:0] mask_q, mask_d;
	logic [15:0] interval_q, interval_d;
	logic [31:0] dead_q, dead_d;
	logic [31:0] dr_q, dr_d;
	logic [ohfe_pkg::NBR_W-1:0] nbr_q, nbr_d;

	logic take;
	logic [ohfe_pkg::POS_W-1:0] o_pos, h_pos;
	logic have0, have_close;
	ohfe_pkg::result_t item0, close_item;

	assign take = vld_s1 && room;
	assign frame.ready = !vld_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (frame.ready) begin
			vld_s1 <= frame.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.valid && frame.ready) begin
			byte_s1 <= frame.data_byte;
			fin_s1 <= frame.frame_end;
		end
	end

	always_comb begin
		shift_d = {shift_q[23:0], byte_s1};
		pos_d = pos_q;
		ihl_d = ihl_q;
		rej_d = rej_q;
		hello_d = hello_q;
		router_d = router_q;
		area_d = area_q;
		mask_d = mask_q;
		interval_d = interval_q;
		dead_d = dead_q;
		dr_d = dr_q;
		nbr_d = nbr_q;
		have0 = 1'b0;
		have_close = 1'b0;
		item0 = '0;
		close_item = '0;
		o_pos = ohfe_pkg::ETH_LEN + ohfe_pkg::POS_W'(ihl_q);
		h_pos = o_pos + ohfe_pkg::OSPF_LEN;

		if (!rej_q) begin
			if (pos_q == ohfe_pkg::ETHERTYPE_LO_POS) begin
				if (shift_d[15:0] != ohfe_pkg::ETHERTYPE_IPV4) begin
					rej_d = 1'b1;
				end
			end else if (pos_q == ohfe_pkg::ETH_LEN) begin
				ihl_d = {byte_s1[3:0], 2'b00};
				if (byte_s1[7:4] != ohfe_pkg::IP_VERSION || ihl_d < ohfe_pkg::IP_MIN) begin
					rej_d = 1'b1;
				end
			end else if (pos_q > ohfe_pkg::ETH_LEN) begin
				if (pos_q == ohfe_pkg::IP_PROTO_POS && byte_s1 != ohfe_pkg::PROTO_OSPF) begin
					rej_d = 1'b1;
				end else if (pos_q == o_pos + ohfe_pkg::OFS_TYPE &&
						byte_s1 != ohfe_pkg::TYPE_HELLO) begin
					rej_d = 1'b1;
				end else if (pos_q == o_pos + ohfe_pkg::OFS_ROUTER) begin
					router_d = shift_d;
				end else if (pos_q == o_pos + ohfe_pkg::OFS_AREA) begin
					area_d = shift_d;
				end else if (pos_q == h_pos + ohfe_pkg::OFS_MASK) begin
					mask_d = shift_d;
				end else if (pos_q == h_pos + ohfe_pkg::OFS_INTERVAL) begin
					interval_d = shift_d[15:0];
				end else if (pos_q == h_pos + ohfe_pkg::OFS_DEAD) begin
					dead_d = shift_d;
				end else if (pos_q == h_pos + ohfe_pkg::OFS_DR) begin
					dr_d = shift_d;
				end else if (pos_q == h_pos + ohfe_pkg::OFS_BDR) begin
					have0 = 1'b1;
					hello_d = 1'b1;
					item0.kind = ohfe_pkg::KIND_SUMMARY;
					item0.rtr_id = router_q;
					item0.area_id = area_q;
					item0.net_mask = mask_q;
					item0.hello_period = interval_q;
					item0.dead_period = dead_q;
					item0.designated_router = dr_q;
					item0.backup_router = shift_d;
				end else if (hello_q && pos_q >= h_pos + ohfe_pkg::HELLO_FIXED &&
						(pos_q[1:0] - h_pos[1:0]) == 2'd3 &&
						nbr_q < ohfe_pkg::NBR_W'(ohfe_pkg::MAX_NBRS)) begin
					have0 = 1'b1;
					nbr_d = nbr_q + 1'b1;
					item0.kind = ohfe_pkg::KIND_NEIGHBOR;
					item0.neighbor_addr = shift_d;
					item0.neighbor_total = nbr_d;
				end
			end
		end

		if (pos_q != ohfe_pkg::POS_MAX) begin
			pos_d = pos_q + 1'b1;
		end

		if (fin_s1) begin
			if (hello_d && !rej_d) begin
				have_close = 1'b1;
				close_item.kind = ohfe_pkg::KIND_END;
				close_item.neighbor_total = nbr_d;
				close_item.last = 1'b1;
			end
			pos_d = '0;
			ihl_d = '0;
			rej_d = 1'b0;
			hello_d = 1'b0;
			shift_d = '0;
			nbr_d = '0;
		end

		push.n = take ? 2'({1'b0, have0} + {1'b0, have_close}) : 2'd0;
		push.slot0 = have0 ? item0 : close_item;
		push.slot1 = close_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			ihl_q <= '0;
			rej_q <= 1'b0;
			hello_q <= 1'b0;
			shift_q <= '0;
			router_q <= '0;
			area_q <= '0;
			mask_q <= '0;
			interval_q <= '0;
			dead_q <= '0;
			dr_q <= '0;
			nbr_q <= '0;
		end else if (take) begin
			pos_q <= pos_d;
			ihl_q <= ihl_d;
			rej_q <= rej_d;
			hello_q <= hello_d;
			shift_q <= shift_d;
			router_q <= router_d;
			area_q <= area_d;
			mask_q <= mask_d;
			interval_q <= interval_d;
			dead_q <= dead_d;
			dr_q <= dr_d;
			nbr_q <= nbr_d;
		end
	end

endmodule

// ===== rtl/core/ohfe_out_fifo.sv =====
// Small result queue that takes up to two words per cycle and hands out one.
// Depends on ohfe_pkg and ohfe_out_if.

module ohfe_out_fifo (
	input logic clk,
	input logic arst_n,
	input ohfe_pkg::push_t push,
	output logic room,
	ohfe_out_if.source report
);

	ohfe_pkg::result_t mem_q [ohfe_pkg::FIFO_DEPTH];
	logic [ohfe_pkg::PTR_W-1:0] wr_q, rd_q;
	logic [ohfe_pkg::CNT_W-1:0] count_q;
	logic pop;
	ohfe_pkg::result_t head;

	assign pop = report.valid && report.ready;
	assign room = count_q <= ohfe_pkg::CNT_W'(ohfe_pkg::FIFO_DEPTH - 2);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_q] <= push.slot0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_q + 1'b1] <= push.slot1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			wr_q <= wr_q + ohfe_pkg::PTR_W'(push.n);
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			count_q <= count_q + ohfe_pkg::CNT_W'(push.n) - ohfe_pkg::CNT_W'(pop);
		end
	end

	assign report.valid = count_q != '0;
	assign report.kind = head.kind;
	assign report.rtr_id = head.rtr_id;
	assign report.area_id = head.area_id;
	assign report.net_mask = head.net_mask;
	assign report.hello_period = head.hello_period;
	assign report.dead_period = head.dead_period;
	assign report.designated_router = head.designated_router;
	assign report.backup_router = head.backup_router;
	assign report.neighbor_addr = head.neighbor_addr;
	assign report.neighbor_total = head.neighbor_total;
	assign report.last = head.last;

endmodule

// ===== rtl/core/ospf_hello_field_extractor.sv =====
// The block takes one Ethernet frame byte per cycle while the result queue has room for two
// more words. Each byte sits in an input register, is decided there against its frame
// offset, and the words it produces go into a four-entry result queue that drives the
// output channel. A byte that both completes a Hello summary or neighbor word and ends the
// frame yields two words; the output moves one word per cycle while the receiver is ready,
// and the input pauses only while the queue holds fewer than two free entries. Frames
// that are not IPv4 OSPF Hello packets produce no words at all.
// Depends on ohfe_pkg, ohfe_in_if, ohfe_out_if, ohfe_parser and ohfe_out_fifo.

module ospf_hello_field_extractor (
	input logic clk,
	input logic arst_n,
	ohfe_in_if.sink frame,
	ohfe_out_if.source report
);

	ohfe_pkg::push_t push;
	logic room;

	ohfe_parser u_parser (
		.clk (clk),
		.arst_n (arst_n),
		.frame (frame),
		.room (room),
		.push (push)
	);

	ohfe_out_fifo u_out_fifo (
		.clk (clk),
		.arst_n (arst_n),
		.push (push),
		.room (room),
		.report (report)
	);

endmodule

// ===== test/tb_ospf_hello_field_extractor.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for ospf_hello_field_extractor: streams directed and random
// Ethernet frames one byte at a time and checks every result word against its own predictor.
// Depends on ohfe_pkg, ohfe_in_if, ohfe_out_if and the extractor RTL.

module tb_ospf_hello_field_extractor;

	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int RANDOM_BYTES = 670;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_CYCLES = 400;
	localparam int N_DIRECTED = 17;

	localparam logic [15:0] ET_IP4 = ohfe_pkg::ETHERTYPE_IPV4;
	localparam logic [7:0] P_OSPF = ohfe_pkg::PROTO_OSPF;
	localparam logic [7:0] T_HELLO = ohfe_pkg::TYPE_HELLO;

	typedef enum logic [1:0] {
		FILL_RANDOM,
		FILL_ZERO,
		FILL_ONES
	} fill_t;

	typedef struct packed {
		logic [15:0] ethertype;
		logic [7:0] ver_ihl;
		logic [7:0] proto;
		logic [7:0] pkt_type;
		fill_t fill;
		logic [16:0] length;
		logic no_words;
		logic hold_rx;
	} frame_row_t;

	logic clk = 1'b0;
	logic arst_n;

	ohfe_in_if frame_ch();
	ohfe_out_if report_ch();

	ospf_hello_field_extractor i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.frame(frame_ch),
		.report(report_ch)
	);

	// Rows that expect no word at all have that typed in; the others go through the predictor.
	frame_row_t directed_frames [N_DIRECTED] = '{
		'{16'h86DD, 8'h45, P_OSPF, T_HELLO, FILL_RANDOM, 17'd48, 1'b1, 1'b0},
		'{ET_IP4, 8'h65, P_OSPF, T_HELLO, FILL_RANDOM, 17'd48, 1'b1, 1'b0},
		'{ET_IP4, 8'h44, P_OSPF, T_HELLO, FILL_RANDOM, 17'd48, 1'b1, 1'b0},
		'{ET_IP4, 8'h40, P_OSPF, T_HELLO, FILL_RANDOM, 17'd48, 1'b1, 1'b0},
		'{ET_IP4, 8'h45, 8'd6, T_HELLO, FILL_RANDOM, 17'd48, 1'b1, 1'b0},
		'{ET_IP4, 8'h45, P_OSPF, 8'd2, FILL_RANDOM, 17'd48, 1'b1, 1'b0},
		'{16'h0000, 8'h00, 8'h00, 8'h00, FILL_ZERO, 17'd48, 1'b1, 1'b0},
		'{16'hFFFF, 8'hFF, 8'hFF, 8'hFF, FILL_ONES, 17'd48, 1'b1, 1'b0},
		'{ET_IP4, 8'h45, P_OSPF, T_HELLO, FILL_RANDOM, 17'd77, 1'b1, 1'b0},
		'{ET_IP4, 8'h45, P_OSPF, T_HELLO, FILL_RANDOM, 17'd1, 1'b1, 1'b0},
		'{ET_IP4, 8'h45, P_OSPF, T_HELLO, FILL_RANDOM, 17'd78, 1'b0, 1'b0},
		'{ET_IP4, 8'h45, P_OSPF, T_HELLO, FILL_ZERO, 17'd82, 1'b0, 1'b0},
		'{ET_IP4, 8'h4F, P_OSPF, T_HELLO, FILL_ONES, 17'd132, 1'b0, 1'b0},
		'{ET_IP4, 8'h45, P_OSPF, T_HELLO, FILL_RANDOM, 17'd86, 1'b0, 1'b0},
		'{ET_IP4, 8'h45, P_OSPF, T_HELLO, FILL_RANDOM, 17'd213, 1'b0, 1'b1},
		'{ET_IP4, 8'h45, P_OSPF, T_HELLO, FILL_RANDOM, 17'd140, 1'b0, 1'b0},
		'{ET_IP4, 8'h45, P_OSPF, T_HELLO, FILL_RANDOM, 17'd90, 1'b0, 1'b0}
	};

	logic [ohfe_pkg::POS_W-1:0] pos_count = '0;
	logic [5:0] ip_hdr_len = '0;
	logic frame_dropped = 1'b0;
	logic hello_seen = 1'b0;
	logic [31:0] byte_window = '0;
	logic [31:0] router_reg = '0;
	logic [31:0] area_reg = '0;
	logic [31:0] mask_reg = '0;
	logic [15:0] interval_reg = '0;
	logic [31:0] dead_reg = '0;
	logic [31:0] dr_reg = '0;
	logic [ohfe_pkg::NBR_W-1:0] nbr_seen = '0;

	ohfe_pkg::result_t pending_words [$];
	logic quiet_frame = 1'b0;
	int errors = 0;
	int cycles = 0;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	logic pressure_req = 1'b0;
	logic pressure_seen = 1'b0;
	int hold_left = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic expect_word(input ohfe_pkg::result_t word);
		if (!quiet_frame) begin
			pending_words.push_back(word);
		end
	endtask

	task automatic track_byte(input logic [7:0] value, input logic last_byte);
		int p;
		int ospf_start;
		int body_start;
		int nbr_ofs;
		ohfe_pkg::result_t word;
		p = int'(pos_count);
		byte_window = {byte_window[23:0], value};
		if (!frame_dropped) begin
			if (p == ohfe_pkg::ETHERTYPE_LO_POS) begin
				if (byte_window[15:0] != ohfe_pkg::ETHERTYPE_IPV4) frame_dropped = 1'b1;
			end else if (p == ohfe_pkg::ETH_LEN) begin
				ip_hdr_len = {value[3:0], 2'b00};
				if (value[7:4] != ohfe_pkg::IP_VERSION || ip_hdr_len < ohfe_pkg::IP_MIN) begin
					frame_dropped = 1'b1;
				end
			end else if (p > ohfe_pkg::ETH_LEN) begin
				ospf_start = int'(ohfe_pkg::ETH_LEN) + int'(ip_hdr_len);
				body_start = ospf_start + int'(ohfe_pkg::OSPF_LEN);
				nbr_ofs = p - body_start - int'(ohfe_pkg::HELLO_FIXED);
				if (p == ohfe_pkg::IP_PROTO_POS && value != ohfe_pkg::PROTO_OSPF) begin
					frame_dropped = 1'b1;
				end else if (p == ospf_start + ohfe_pkg::OFS_TYPE &&
						value != ohfe_pkg::TYPE_HELLO) begin
					frame_dropped = 1'b1;
				end else if (p == ospf_start + ohfe_pkg::OFS_ROUTER) begin
					router_reg = byte_window;
				end else if (p == ospf_start + ohfe_pkg::OFS_AREA) begin
					area_reg = byte_window;
				end else if (p == body_start + ohfe_pkg::OFS_MASK) begin
					mask_reg = byte_window;
				end else if (p == body_start + ohfe_pkg::OFS_INTERVAL) begin
					interval_reg = byte_window[15:0];
				end else if (p == body_start + ohfe_pkg::OFS_DEAD) begin
					dead_reg = byte_window;
				end else if (p == body_start + ohfe_pkg::OFS_DR) begin
					dr_reg = byte_window;
				end else if (p == body_start + ohfe_pkg::OFS_BDR) begin
					word = '0;
					word.kind = ohfe_pkg::KIND_SUMMARY;
					word.rtr_id = router_reg;
					word.area_id = area_reg;
					word.net_mask = mask_reg;
					word.hello_period = interval_reg;
					word.dead_period = dead_reg;
					word.designated_router = dr_reg;
					word.backup_router = byte_window;
					expect_word(word);
					hello_seen = 1'b1;
				end else if (hello_seen && nbr_ofs >= 0 && nbr_ofs[1:0] == 2'b11 &&
						nbr_seen < ohfe_pkg::MAX_NBRS) begin
					nbr_seen = nbr_seen + 1'b1;
					word = '0;
					word.kind = ohfe_pkg::KIND_NEIGHBOR;
					word.neighbor_addr = byte_window;
					word.neighbor_total = nbr_seen;
					expect_word(word);
				end
			end
		end
		if (pos_count != ohfe_pkg::POS_MAX) pos_count = pos_count + 1'b1;
		if (last_byte) begin
			if (hello_seen && !frame_dropped) begin
				word = '0;
				word.kind = ohfe_pkg::KIND_END;
				word.neighbor_total = nbr_seen;
				word.last = 1'b1;
				expect_word(word);
			end
			pos_count = '0;
			ip_hdr_len = '0;
			frame_dropped = 1'b0;
			hello_seen = 1'b0;
			byte_window = '0;
			nbr_seen = '0;
		end
	endtask

	task automatic offer_byte(input logic [7:0] value, input logic last_byte);
		while ($urandom_range(99) < tx_idle_pct) begin
			frame_ch.valid <= 1'b0;
			@(posedge clk);
		end
		frame_ch.valid <= 1'b1;
		frame_ch.data_byte <= value;
		frame_ch.frame_end <= last_byte;
		do @(posedge clk); while (!frame_ch.ready);
		track_byte(value, last_byte);
	endtask

	task automatic send_frame(input frame_row_t f);
		int type_pos;
		logic [7:0] value;
		type_pos = int'(ohfe_pkg::ETH_LEN) + int'(f.ver_ihl[3:0]) * 4 +
			int'(ohfe_pkg::OFS_TYPE);
		for (int i = 0; i < f.length; i++) begin
			case (f.fill)
				FILL_ZERO: value = 8'h00;
				FILL_ONES: value = 8'hFF;
				default: value = 8'($urandom);
			endcase
			if (i == ohfe_pkg::ETHERTYPE_LO_POS - 1) value = f.ethertype[15:8];
			else if (i == ohfe_pkg::ETHERTYPE_LO_POS) value = f.ethertype[7:0];
			else if (i == ohfe_pkg::ETH_LEN) value = f.ver_ihl;
			else if (i == ohfe_pkg::IP_PROTO_POS) value = f.proto;
			else if (i == type_pos) value = f.pkt_type;
			offer_byte(value, i == f.length - 1);
		end
	endtask

	function automatic frame_row_t random_frame();
		frame_row_t f;
		int pick;
		int body_start;
		int nbrs;
		pick = $urandom_range(99);
		f.ethertype = ohfe_pkg::ETHERTYPE_IPV4;
		f.ver_ihl = {ohfe_pkg::IP_VERSION, 4'd5};
		if ($urandom_range(3) == 0) f.ver_ihl[3:0] = 4'($urandom_range(15, 5));
		f.proto = ohfe_pkg::PROTO_OSPF;
		f.pkt_type = ohfe_pkg::TYPE_HELLO;
		f.fill = FILL_RANDOM;
		f.no_words = 1'b0;
		f.hold_rx = 1'b0;
		body_start = int'(ohfe_pkg::ETH_LEN) + int'(f.ver_ihl[3:0]) * 4 +
			int'(ohfe_pkg::OSPF_LEN);
		if ($urandom_range(19) == 0) nbrs = $urandom_range(36, 28);
		else nbrs = $urandom_range(4);
		f.length = 17'(body_start + int'(ohfe_pkg::HELLO_FIXED) + 4 * nbrs +
			int'($urandom_range(3)));
		if (pick >= 70 && pick < 80) begin
			case ($urandom_range(4))
				0: begin
					f.ethertype = 16'($urandom);
					if (f.ethertype == ohfe_pkg::ETHERTYPE_IPV4) f.ethertype[15] = 1'b1;
				end
				1: begin
					f.ver_ihl[7:4] = 4'($urandom);
					if (f.ver_ihl[7:4] == ohfe_pkg::IP_VERSION) f.ver_ihl[7:4] = 4'd6;
				end
				2: f.ver_ihl[3:0] = 4'($urandom_range(4));
				3: begin
					f.proto = 8'($urandom);
					if (f.proto == ohfe_pkg::PROTO_OSPF) f.proto[7] = 1'b1;
				end
				default: begin
					f.pkt_type = 8'($urandom);
					if (f.pkt_type == ohfe_pkg::TYPE_HELLO) f.pkt_type = 8'd0;
				end
			endcase
		end else if (pick >= 80 && pick < 90) begin
			f.length = 17'($urandom_range(body_start + int'(ohfe_pkg::HELLO_FIXED) - 1, 1));
		end else if (pick >= 90) begin
			f.ethertype = 16'($urandom);
			f.ver_ihl = 8'($urandom);
			f.proto = 8'($urandom);
			f.pkt_type = 8'($urandom);
			f.length = 17'($urandom_range(120, 1));
		end
		return f;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("ERROR: run did not finish within %0d cycles", LIMIT_CYCLES);
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		ohfe_pkg::result_t got;
		ohfe_pkg::result_t want;
		if (report_ch.valid && report_ch.ready) begin
			got.kind = report_ch.kind;
			got.rtr_id = report_ch.rtr_id;
			got.area_id = report_ch.area_id;
			got.net_mask = report_ch.net_mask;
			got.hello_period = report_ch.hello_period;
			got.dead_period = report_ch.dead_period;
			got.designated_router = report_ch.designated_router;
			got.backup_router = report_ch.backup_router;
			got.neighbor_addr = report_ch.neighbor_addr;
			got.neighbor_total = report_ch.neighbor_total;
			got.last = report_ch.last;
			if (pending_words.size() == 0) begin
				errors++;
				if (errors <= 10) $display("ERROR: word of kind %0d with nothing expected",
					got.kind);
			end else begin
				want = pending_words.pop_front();
				if (got.kind !== want.kind || got.rtr_id !== want.rtr_id ||
						got.area_id !== want.area_id || got.net_mask !== want.net_mask ||
						got.hello_period !== want.hello_period ||
						got.dead_period !== want.dead_period ||
						got.designated_router !== want.designated_router ||
						got.backup_router !== want.backup_router ||
						got.neighbor_addr !== want.neighbor_addr ||
						got.neighbor_total !== want.neighbor_total ||
						got.last !== want.last) begin
					errors++;
					if (errors <= 10) begin
						$display("ERROR: expected kind %0d rid %h aid %h mask %h hi %h",
							want.kind, want.rtr_id, want.area_id, want.net_mask,
							want.hello_period);
						$display("       dead %h dr %h bdr %h nbr %h total %0d last %b",
							want.dead_period, want.designated_router, want.backup_router,
							want.neighbor_addr, want.neighbor_total, want.last);
						$display("  got  kind %0d rid %h aid %h mask %h hi %h",
							got.kind, got.rtr_id, got.area_id, got.net_mask,
							got.hello_period);
						$display("       dead %h dr %h bdr %h nbr %h total %0d last %b",
							got.dead_period, got.designated_router, got.backup_router,
							got.neighbor_addr, got.neighbor_total, got.last);
					end
				end
			end
		end
		if (pressure_req && !pressure_seen) begin
			pressure_seen = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (!arst_n) begin
			report_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left = hold_left - 1;
			report_ch.ready <= 1'b0;
		end else begin
			report_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	initial begin
		frame_row_t f;
		int random_sent;
		int phase;
		random_sent = 0;
		arst_n <= 1'b0;
		frame_ch.valid <= 1'b0;
		frame_ch.data_byte <= 8'h00;
		frame_ch.frame_end <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			quiet_frame = directed_frames[i].no_words;
			if (directed_frames[i].hold_rx) pressure_req <= 1'b1;
			send_frame(directed_frames[i]);
		end
		quiet_frame = 1'b0;

		while (random_sent < RANDOM_BYTES) begin
			phase = random_sent * 4 / RANDOM_BYTES;
			case (phase)
				0: begin
					tx_idle_pct = 0;
					rx_stall_pct = 0;
				end
				1: begin
					tx_idle_pct = 81;
					rx_stall_pct = 0;
				end
				2: begin
					tx_idle_pct = 0;
					rx_stall_pct = 81;
				end
				default: begin
					tx_idle_pct = 36;
					rx_stall_pct = 36;
				end
			endcase
			f = random_frame();
			send_frame(f);
			random_sent += int'(f.length);
		end
		frame_ch.valid <= 1'b0;

		while (pending_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending_words.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
